### hw/rtl/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg: shared types and constants of the page replacement engine
// Frame counts, policy codes, FSM states and the cell command bundle.
// ----------------------------------------------------------------------------
package pre_pkg;

  localparam int unsigned NUM_PAGES  = 1024;
  localparam int unsigned MAX_FRAMES = 64;
  localparam int unsigned PAGE_W     = 10;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned USED_W     = 7;
  localparam int unsigned CNT_W      = 24;

  localparam logic [CNT_W-1:0] CNT_MAX   = 24'hFFFFFF;
  localparam logic [15:0]      LFSR_SEED = 16'hACE1;
  localparam logic [15:0]      LFSR_TAPS = 16'hB400;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_RAND = 2'd2;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_PSIZE  = 2'd1;
  localparam logic [1:0] REG_FLIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DEC,
    ST_RAND,
    ST_FIND,
    ST_EMIT
  } pre_state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
  } pre_entry_t;

  typedef struct packed {
    logic               shift_en;
    logic [FRAME_W-1:0] pos;
    logic [USED_W-1:0]  used;
    logic [PAGE_W-1:0]  key_page;
    logic [FRAME_W-1:0] key_frame;
  } pre_cmd_t;

endpackage

### hw/rtl/pre_cell.sv
// ----------------------------------------------------------------------------
// pre_cell: one slot of the recency/order list
// Holds a frame and its owning page; takes the upstream slot on a shift.
// ----------------------------------------------------------------------------
module pre_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  pre_pkg::pre_cmd_t   cmd,
  input  pre_pkg::pre_entry_t prev,
  output pre_pkg::pre_entry_t ent,
  output logic               match_page,
  output logic               match_frame
);
  import pre_pkg::*;

  localparam logic [USED_W-1:0] IdxV = USED_W'(IDX);

  logic valid;

  assign valid       = IdxV < cmd.used;
  assign match_page  = valid && (ent.page == cmd.key_page);
  assign match_frame = valid && (ent.frame == cmd.key_frame);

  // slots at or in front of pos move back one place
  always_ff @(posedge clk) begin
    if (cmd.shift_en && (IdxV <= {1'b0, cmd.pos})) begin
      ent <= prev;
    end
  end

endmodule

### hw/rtl/page_replacement_engine.sv
// ----------------------------------------------------------------------------
// page_replacement_engine: FIFO / LRU / random page replacement
// Resident pages live in a chain of slots ordered newest/most recent first.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_       in   tdata: logical_address[31:0]; tuser: kind
// m_       out  tdata: page, frame, fault, replaced, out_of_range, 3 counts
// cfg_     in   write enable, index, data
//
// A transaction steps through accept, lookup, decide and emit. Random
// replacement adds an LFSR step state, repeated until a used frame comes up,
// and a state to locate that frame in the chain. Reset is synchronous and
// needs no clearing pass. The next item is accepted while a result waits;
// emit stalls until the output register is free.
// ----------------------------------------------------------------------------
module page_replacement_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // logical_address[31:0]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  // page_number[9:0], frame_number[15:10], fault[16], replaced[17],
  // out_of_range[18], reference_count[42:19], fault_count[66:43],
  // replace_count[90:67], zero fill [95:91]
  output logic [95:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import pre_pkg::*;

  pre_state_t state, state_next;

  logic [1:0]  policy;
  logic [4:0]  psize;
  logic [6:0]  flimit;

  logic               clr_r, oor_r, hit_r, move_r, fault_r, repl_r, alloc_r;
  logic [PAGE_W-1:0]  pg_r;
  logic [FRAME_W-1:0] frame_r, pos_r, hit_pos_r;
  logic [FRAME_W-1:0] hit_frame_r;
  logic [USED_W-1:0]  frames_used;
  logic [15:0]        lfsr;
  logic [CNT_W-1:0]   ref_cnt, flt_cnt, rep_cnt;

  pre_cmd_t   cmd;
  pre_entry_t chain [MAX_FRAMES+1];
  logic [MAX_FRAMES-1:0] mpage, mframe;

  logic               accept, out_free, emit;
  logic [31:0]        shifted;
  logic [USED_W-1:0]  limit;
  logic [15:0]        lfsr_step;
  logic [FRAME_W-1:0] mpage_idx, mframe_idx, mpage_frame, victim_frame;
  logic [FRAME_W-1:0] last_pos;
  logic [CNT_W-1:0]   ref_n, flt_n, rep_n;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_EMIT) && out_free;
  assign shifted  = s_tdata >> psize;
  assign last_pos = FRAME_W'(frames_used - USED_W'(1));

  always_comb begin
    if (flimit == '0) begin
      limit = USED_W'(1);
    end else if (flimit > USED_W'(MAX_FRAMES)) begin
      limit = USED_W'(MAX_FRAMES);
    end else begin
      limit = flimit;
    end
  end

  assign lfsr_step = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);

  // cell chain
  assign chain[0] = '{frame: frame_r, page: pg_r};
  assign cmd.shift_en  = emit && !clr_r && !oor_r && move_r;
  assign cmd.pos       = pos_r;
  assign cmd.used      = frames_used;
  assign cmd.key_page  = pg_r;
  assign cmd.key_frame = frame_r;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    pre_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .prev       (chain[i]),
      .ent        (chain[i+1]),
      .match_page (mpage[i]),
      .match_frame(mframe[i])
    );
  end

  // one-hot encoders and victim select
  always_comb begin
    mpage_idx    = '0;
    mframe_idx   = '0;
    mpage_frame  = '0;
    victim_frame = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (mpage[i]) begin
        mpage_idx   = mpage_idx | FRAME_W'(i);
        mpage_frame = mpage_frame | chain[i+1].frame;
      end
      if (mframe[i]) begin
        mframe_idx = mframe_idx | FRAME_W'(i);
      end
      if (last_pos == FRAME_W'(i)) begin
        victim_frame = chain[i+1].frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: state_next = ST_DEC;
      ST_DEC: begin
        if (!clr_r && !oor_r && !hit_r && (frames_used >= limit) &&
            (policy == POL_RAND)) begin
          state_next = ST_RAND;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_RAND: begin
        if (USED_W'(lfsr_step[FRAME_W-1:0]) < frames_used) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          clr_r <= s_tuser;
          pg_r  <= shifted[PAGE_W-1:0];
          oor_r <= |shifted[31:PAGE_W];
        end
      end
      ST_LOOK: begin
        hit_r       <= |mpage;
        hit_pos_r   <= mpage_idx;
        hit_frame_r <= mpage_frame;
      end
      ST_DEC: begin
        fault_r <= !hit_r;
        alloc_r <= 1'b0;
        repl_r  <= 1'b0;
        move_r  <= 1'b1;
        if (hit_r) begin
          frame_r <= hit_frame_r;
          pos_r   <= hit_pos_r;
          move_r  <= (policy == POL_LRU);
        end else if (frames_used < limit) begin
          frame_r <= frames_used[FRAME_W-1:0];
          pos_r   <= frames_used[FRAME_W-1:0];
          alloc_r <= 1'b1;
        end else begin
          repl_r  <= 1'b1;
          pos_r   <= last_pos;
          frame_r <= victim_frame;
        end
      end
      ST_RAND: frame_r <= lfsr_step[FRAME_W-1:0];
      ST_FIND: pos_r <= mframe_idx;
      default: ;
    endcase
  end

  always_comb begin
    ref_n = ref_cnt;
    flt_n = flt_cnt;
    rep_n = rep_cnt;
    if (clr_r) begin
      ref_n = '0;
      flt_n = '0;
      rep_n = '0;
    end else if (!oor_r) begin
      if (ref_cnt != CNT_MAX) ref_n = ref_cnt + CNT_W'(1);
      if (fault_r && flt_cnt != CNT_MAX) flt_n = flt_cnt + CNT_W'(1);
      if (repl_r && rep_cnt != CNT_MAX) rep_n = rep_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POL_FIFO;
      psize       <= 5'd12;
      flimit      <= 7'd64;
      lfsr        <= LFSR_SEED;
      frames_used <= '0;
      ref_cnt     <= '0;
      flt_cnt     <= '0;
      rep_cnt     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY: policy <= cfg_data[1:0];
          REG_PSIZE:  psize  <= cfg_data[4:0];
          REG_FLIMIT: flimit <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_RAND) begin
        lfsr <= lfsr_step;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
        ref_cnt  <= ref_n;
        flt_cnt  <= flt_n;
        rep_cnt  <= rep_n;
        if (clr_r) begin
          frames_used <= '0;
        end else if (!oor_r && alloc_r) begin
          frames_used <= frames_used + USED_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (clr_r) begin
        m_tdata <= '0;
      end else if (oor_r) begin
        m_tdata <= {5'd0, rep_n, flt_n, ref_n, 1'b1, 1'b0, 1'b0, 6'd0, pg_r};
      end else begin
        m_tdata <= {5'd0, rep_n, flt_n, ref_n, 1'b0, repl_r, fault_r, frame_r, pg_r};
      end
    end
  end

  a_used_max: assert property (@(posedge clk) disable iff (rst)
    frames_used <= USED_W'(MAX_FRAMES))
    else $error("frames_used above frame count");

  a_find_used: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIND) |-> (USED_W'(frame_r) < frames_used))
    else $error("random victim not a used frame");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (emit && clr_r) |=> (frames_used == '0 && ref_cnt == '0))
    else $error("clear did not empty the table");

endmodule

### sim/page_replacement_engine_tb.sv
// ----------------------------------------------------------------------------
// page_replacement_engine_tb: self-checking bench for the page replacement engine
// Runs a directed table, then randomized reference streams under ten settings of
// policy, page size and frame limit. Results are checked against hand-set values
// or an in-bench model of the page table, recency/arrival order and victim LFSR.
// ----------------------------------------------------------------------------
module page_replacement_engine_tb;
  import pre_pkg::*;

  typedef struct packed {
    logic [4:0]         pad;
    logic [CNT_W-1:0]   repl_cnt;
    logic [CNT_W-1:0]   fault_cnt;
    logic [CNT_W-1:0]   ref_cnt;
    logic               oor;
    logic               repl;
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
  } xlat_t;

  typedef enum logic [2:0] {OP_REF, OP_CLR, OP_POL, OP_PSZ, OP_LIM} op_t;

  typedef struct {
    op_t         op;
    logic [31:0] val;
    bit          typed;
    xlat_t       res;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [95:0] m_tdata;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_POLICY;
  logic [6:0]  cfg_data = '0;

  page_replacement_engine u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // model state
  logic [1:0]         pol;
  logic [4:0]         psz;
  logic [6:0]         lim;
  bit                 pvalid [NUM_PAGES];
  logic [FRAME_W-1:0] pframe [NUM_PAGES];
  logic [PAGE_W-1:0]  owner  [MAX_FRAMES];
  logic [FRAME_W-1:0] order  [MAX_FRAMES];
  int unsigned        used;
  logic [15:0]        lfsr;
  logic [CNT_W-1:0]   refs, faults, repls;

  xlat_t expected_q[$];
  row_t  rows[$];
  int    errors = 0, n_rcv = 0, n_sent = 0, idle_cycles = 0;
  int    n_fault = 0, n_repl = 0, n_oor = 0, n_clr = 0;
  bit    burst = 0;

  function automatic logic [CNT_W-1:0] sat(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void clear_table();
    foreach (pvalid[i]) pvalid[i] = 0;
    used = 0;
    refs = '0;
    faults = '0;
    repls = '0;
  endfunction

  function automatic void to_front(int unsigned pos);
    logic [FRAME_W-1:0] f;
    f = order[pos];
    for (int unsigned i = pos; i > 0; i--) order[i] = order[i-1];
    order[0] = f;
  endfunction

  function automatic int unsigned pos_of(logic [FRAME_W-1:0] f);
    for (int unsigned i = 0; i < used; i++)
      if (order[i] == f) return i;
    return 0;
  endfunction

  function automatic xlat_t translate(logic kind, logic [31:0] addr);
    xlat_t       r;
    logic [31:0] pg;
    int unsigned cap, pos;
    logic [FRAME_W-1:0] fr, cand;
    r = '0;
    if (kind) begin
      clear_table();
      return r;
    end
    pg = addr >> psz;
    r.page = pg[PAGE_W-1:0];
    if (pg >= NUM_PAGES) begin
      r.oor = 1;
      r.ref_cnt = refs;
      r.fault_cnt = faults;
      r.repl_cnt = repls;
      return r;
    end
    cap = (lim == 0) ? 1 : (lim > MAX_FRAMES) ? MAX_FRAMES : lim;
    refs = sat(refs);
    if (pvalid[pg]) begin
      fr = pframe[pg];
      if (pol == POL_LRU) to_front(pos_of(fr));
    end else begin
      r.fault = 1;
      faults = sat(faults);
      if (used < cap) begin
        fr = FRAME_W'(used);
        order[used] = fr;
        used++;
        to_front(used - 1);
      end else begin
        r.repl = 1;
        repls = sat(repls);
        if (pol == POL_RAND) begin
          do begin
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
            cand = lfsr[FRAME_W-1:0];
          end while (cand >= used);
          fr = cand;
          pos = pos_of(fr);
        end else begin
          pos = used - 1;
          fr = order[pos];
        end
        pvalid[owner[fr]] = 0;
        to_front(pos);
      end
      owner[fr] = pg[PAGE_W-1:0];
      pframe[pg] = fr;
      pvalid[pg] = 1;
    end
    r.frame = fr;
    r.ref_cnt = refs;
    r.fault_cnt = faults;
    r.repl_cnt = repls;
    return r;
  endfunction

  function automatic xlat_t mk(int pg, int fr, bit fa, bit rp, bit oo, int rc, int fc, int pc);
    xlat_t r;
    r = '0;
    r.page = PAGE_W'(pg); r.frame = FRAME_W'(fr); r.fault = fa; r.repl = rp; r.oor = oo;
    r.ref_cnt = CNT_W'(rc); r.fault_cnt = CNT_W'(fc); r.repl_cnt = CNT_W'(pc);
    return r;
  endfunction

  function automatic void add(op_t op, logic [31:0] v);
    rows.insert(rows.size(), '{op, v, 0, '0});
  endfunction

  function automatic void add_exp(op_t op, logic [31:0] v, xlat_t r);
    rows.insert(rows.size(), '{op, v, 1, r});
  endfunction

  task automatic idle_gap();
    int g;
    g = burst ? 0 : ($urandom_range(0, 99) < 45) ? 0 :
        ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(15, 50);
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_item(logic kind, logic [31:0] addr, bit typed, xlat_t tv);
    xlat_t r;
    idle_gap();
    s_tvalid <= 1;
    s_tuser  <= kind;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
    r = translate(kind, addr);
    expected_q.insert(expected_q.size(), typed ? tv : r);
    n_sent++;
  endtask

  // block idle: nothing in flight, then a short settle
  task automatic drain();
    s_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] v);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_POLICY: pol = v[1:0];
      REG_PSIZE:  psz = v[4:0];
      default:    lim = v;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      xlat_t a, e;
      a = m_tdata;
      n_rcv++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", m_tdata);
      end else begin
        e = expected_q.pop_front();
        if (a.page != e.page || a.frame != e.frame || a.fault != e.fault ||
            a.repl != e.repl || a.oor != e.oor || a.ref_cnt != e.ref_cnt ||
            a.fault_cnt != e.fault_cnt || a.repl_cnt != e.repl_cnt) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch #%0d exp pg=%0d fr=%0d f=%b r=%b o=%b cnt=%0d/%0d/%0d",
                     n_rcv, e.page, e.frame, e.fault, e.repl, e.oor, e.ref_cnt,
                     e.fault_cnt, e.repl_cnt);
            $display("            got pg=%0d fr=%0d f=%b r=%b o=%b cnt=%0d/%0d/%0d",
                     a.page, a.frame, a.fault, a.repl, a.oor, a.ref_cnt,
                     a.fault_cnt, a.repl_cnt);
          end
        end
        n_fault += e.fault;
        n_repl  += e.repl;
        n_oor   += e.oor;
      end
    end
  end

  // receiver: random back-pressure, one long hold-off to fill the block
  initial begin
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && n_rcv >= 250) begin
        held = 1;
        m_tready <= 0;
        repeat (300) @(posedge clk);
      end else if (!burst && $urandom_range(0, 99) < 3) begin
        m_tready <= 0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        m_tready <= burst ? 1'b1 : ($urandom_range(0, 99) < 75);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [6:0] phases[10][3];
    logic [63:0] maxpg;
    logic [31:0] pool[$];
    logic [31:0] addr;
    int          cap, k;

    phases = '{'{0, 0, 1}, '{1, 12, 64}, '{2, 16, 8}, '{3, 4, 127}, '{1, 2, 3},
               '{2, 0, 64}, '{0, 31, 5}, '{2, 8, 2}, '{1, 10, 0}, '{0, 5, 16}};
    pol = POL_FIFO; psz = 12; lim = 64; lfsr = LFSR_SEED;
    clear_table();

    add_exp(OP_CLR, 0, mk(0, 0, 0, 0, 0, 0, 0, 0));
    add(OP_PSZ, 0); add(OP_LIM, 2); add(OP_POL, POL_FIFO);
    add_exp(OP_REF, 0, mk(0, 0, 1, 0, 0, 1, 1, 0));
    add_exp(OP_REF, 1, mk(1, 1, 1, 0, 0, 2, 2, 0));
    add_exp(OP_REF, 0, mk(0, 0, 0, 0, 0, 3, 2, 0));
    add_exp(OP_REF, 2, mk(2, 0, 1, 1, 0, 4, 3, 1));
    add_exp(OP_REF, 32'hFFFF_FFFF, mk(1023, 0, 0, 0, 1, 4, 3, 1));
    add(OP_REF, 1023);
    add(OP_POL, POL_LRU); add(OP_REF, 1); add(OP_REF, 2); add(OP_REF, 5);
    add(OP_POL, POL_RAND); add(OP_REF, 7); add(OP_REF, 9); add(OP_REF, 11);
    add(OP_POL, 3); add(OP_REF, 12); add(OP_REF, 13);
    add(OP_LIM, 0); add(OP_REF, 14);
    add(OP_LIM, 127); add(OP_REF, 15); add(OP_REF, 16);
    add(OP_LIM, 1); add(OP_REF, 17);
    add(OP_PSZ, 31); add(OP_REF, 32'hFFFF_FFFF);
    add(OP_PSZ, 16); add(OP_REF, 32'hFFFF_0000);
    add(OP_CLR, 0); add(OP_REF, 32'h0000_0000);

    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].op)
        OP_POL:  write_reg(REG_POLICY, rows[i].val[6:0]);
        OP_PSZ:  write_reg(REG_PSIZE, rows[i].val[6:0]);
        OP_LIM:  write_reg(REG_FLIMIT, rows[i].val[6:0]);
        default: send_item(rows[i].op == OP_CLR, rows[i].val, rows[i].typed, rows[i].res);
      endcase
    end

    for (int p = 0; p < 10; p++) begin
      write_reg(REG_POLICY, phases[p][0]);
      write_reg(REG_PSIZE, phases[p][1]);
      write_reg(REG_FLIMIT, phases[p][2]);
      maxpg = (64'h1_0000_0000 >> psz) - 1;
      if (maxpg > NUM_PAGES - 1) maxpg = NUM_PAGES - 1;
      cap = (lim == 0) ? 1 : (lim > MAX_FRAMES) ? MAX_FRAMES : lim;
      pool.delete();
      repeat (cap + $urandom_range(1, 8))
        pool.insert(pool.size(), $urandom_range(0, maxpg[31:0]));
      for (int n = 0; n < 63; n++) begin
        burst = (n >= 20 && n < 35);
        k = $urandom_range(0, 99);
        if (k < 3) begin
          send_item(1, $urandom, 0, '0);
          n_clr++;
        end else if (k < 10) begin
          send_item(0, $urandom, 0, '0);
        end else begin
          addr = (pool[$urandom_range(0, pool.size() - 1)] << psz) |
                 ($urandom & 32'((64'd1 << psz) - 1));
          send_item(0, addr, 0, '0);
        end
      end
      burst = 0;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d items over 4 policy codes, page sizes 1..2^31, frame limits 0..127",
             n_sent);
    $display("%0d faults, %0d replacements, %0d out of range, %0d random clears",
             n_fault, n_repl, n_oor, n_clr);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
